### sv/rsas_pkg.sv
package rsas_pkg;

  localparam int COUNT_W = 11;
  localparam int INDEX_W = 10;
  localparam int VALUE_W = 32;

  // input tdata layout, lowest bit up
  localparam int POS_LSB    = 0;
  localparam int VAL_LSB    = POS_LSB + INDEX_W;
  localparam int KEY_LSB    = VAL_LSB + VALUE_W;
  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 16;

  typedef enum logic [0:0] {
    FUNC_WRITE  = 1'b0,
    FUNC_SEARCH = 1'b1
  } func_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_FETCH_HI,
    ST_EVAL,
    ST_DONE
  } rsas_state_t;

  typedef struct packed {
    logic               found;
    logic [INDEX_W-1:0] index;
  } rsas_result_t;

endpackage

### sv/rsas_mem.sv
module rsas_mem import rsas_pkg::*; #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int DW    = 32
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic [AW-1:0] rd0_addr,
  input  logic [AW-1:0] rd1_addr,
  output logic [DW-1:0] rd0_data,
  output logic [DW-1:0] rd1_data
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd0_data_r;
  logic [DW-1:0] rd1_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd0_data_r <= mem[rd0_addr];
    rd1_data_r <= mem[rd1_addr];
  end

  assign rd0_data = rd0_data_r;
  assign rd1_data = rd1_data_r;

endmodule

### sv/rsas_search.sv
module rsas_search import rsas_pkg::*; #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int DW    = 32,
  parameter int BW    = 13
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic signed [DW-1:0] start_key,
  input  logic [COUNT_W-1:0]   count,
  output logic                 idle,
  output logic [AW-1:0]        rd0_addr,
  output logic [AW-1:0]        rd1_addr,
  input  logic [DW-1:0]        rd0_data,
  input  logic [DW-1:0]        rd1_data,
  output logic                 res_valid,
  input  logic                 res_ready,
  output rsas_result_t         res
);

  rsas_state_t state_r, state_nxt;

  logic signed [BW-1:0] low_r, low_nxt;
  logic signed [BW-1:0] high_r, high_nxt;
  logic signed [BW-1:0] mid_r, mid_nxt;
  logic signed [DW-1:0] key_r, key_nxt;
  logic signed [DW-1:0] vm_r, vm_nxt;
  logic signed [DW-1:0] vl_r, vl_nxt;
  logic                 hit_r, hit_nxt;

  logic signed [BW-1:0] count_ext;
  logic signed [BW-1:0] count_sat;
  logic signed [BW-1:0] mid_cur;
  logic signed [BW-1:0] new_low;
  logic signed [BW-1:0] new_high;
  logic signed [BW-1:0] new_mid;
  logic signed [DW-1:0] vh;
  logic                 go_left;
  logic signed [BW-1:0] rd0_addr_b;
  logic signed [BW-1:0] rd1_addr_b;

  assign count_ext = $signed(BW'(count));
  assign count_sat = (count_ext > $signed(BW'(DEPTH))) ? $signed(BW'(DEPTH)) : count_ext;

  assign mid_cur = low_r + ((high_r - low_r) >>> 1);
  assign vh      = $signed(rd1_data);

  // keep the half that can hold the key
  always_comb begin
    if (vl_r <= vm_r) begin
      go_left = (key_r >= vl_r) && (key_r <= vm_r);
    end else begin
      go_left = !((key_r >= vm_r) && (key_r <= vh));
    end
  end

  assign new_low  = go_left ? low_r : mid_r + BW'(1);
  assign new_high = go_left ? mid_r - BW'(1) : high_r;
  assign new_mid  = new_low + ((new_high - new_low) >>> 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      low_r   <= '0;
      high_r  <= '0;
      hit_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      low_r   <= low_nxt;
      high_r  <= high_nxt;
      hit_r   <= hit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mid_r <= mid_nxt;
    key_r <= key_nxt;
    vm_r  <= vm_nxt;
    vl_r  <= vl_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    low_nxt    = low_r;
    high_nxt   = high_r;
    mid_nxt    = mid_r;
    key_nxt    = key_r;
    vm_nxt     = vm_r;
    vl_nxt     = vl_r;
    hit_nxt    = hit_r;
    rd0_addr_b = mid_cur;
    rd1_addr_b = low_r;
    res_valid  = 1'b0;
    idle       = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        idle = 1'b1;
        if (start) begin
          key_nxt   = start_key;
          low_nxt   = '0;
          high_nxt  = count_sat - BW'(1);
          hit_nxt   = 1'b0;
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        // reads of mid and low go out this cycle
        if (low_r <= high_r) begin
          mid_nxt   = mid_cur;
          state_nxt = ST_FETCH_HI;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_FETCH_HI: begin
        vm_nxt     = $signed(rd0_data);
        vl_nxt     = $signed(rd1_data);
        rd1_addr_b = high_r;
        state_nxt  = ST_EVAL;
      end
      ST_EVAL: begin
        // next probe reads issue speculatively from the new bounds
        rd0_addr_b = new_mid;
        rd1_addr_b = new_low;
        if (vm_r == key_r) begin
          hit_nxt   = 1'b1;
          state_nxt = ST_DONE;
        end else begin
          low_nxt  = new_low;
          high_nxt = new_high;
          if (new_low <= new_high) begin
            mid_nxt   = new_mid;
            state_nxt = ST_FETCH_HI;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign rd0_addr = rd0_addr_b[AW-1:0];
  assign rd1_addr = rd1_addr_b[AW-1:0];

  assign res.found = hit_r;
  assign res.index = hit_r ? mid_r[INDEX_W-1:0] : '0;

endmodule

### sv/rotated_sorted_array_search.sv
// Search over a rotated ascending sequence of distinct signed words.
// Input channel in_*: in_tuser selects the operation (0 writes one element,
// 1 searches for a key). A write stores element_value at write_position and
// gives no result; positions at or beyond STORE_DEPTH are dropped. A search
// gives one result item on out_*: found flag and the index of the key.
// cfg_wr_en/cfg_wr_data load element_count, saturated to STORE_DEPTH.
// A search makes P probes before its result reaches the result register, P
// being the number of probes (at most about log2(element_count)+1); each
// probe costs a mid/low read on the two read ports, then a read of the high
// bound, then the compare.
// Items are taken one at a time: in_tready is high only while no search runs.
// A finished result sits in an output register; if out_tready is low the
// next item is still accepted, and a later search waits for the slot.
// Reset sets element_count to 1 and empties the output register; the store
// contents are undefined until written.
module rotated_sorted_array_search import rsas_pkg::*; #(
  parameter int STORE_DEPTH = 1024,
  parameter int DATA_WIDTH  = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,  // write_position, element_value, search_key
  input  logic                  in_tuser,  // func
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata, // found, found_index
  input  logic                  cfg_wr_en,
  input  logic [COUNT_W-1:0]    cfg_wr_data
);

  localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int BW = ((AW > COUNT_W) ? AW : COUNT_W) + 2;

  logic [COUNT_W-1:0] count_r;
  logic               out_valid_r;
  rsas_result_t       out_data_r;

  logic                      eng_idle;
  logic                      in_fire;
  logic                      wr_en;
  logic                      start;
  logic [INDEX_W-1:0]        in_pos;
  logic [VALUE_W-1:0]        in_value;
  logic [VALUE_W-1:0]        in_key;
  logic [AW-1:0]             rd0_addr;
  logic [AW-1:0]             rd1_addr;
  logic [DATA_WIDTH-1:0]     rd0_data;
  logic [DATA_WIDTH-1:0]     rd1_data;
  logic                      res_valid;
  logic                      res_ready;
  rsas_result_t              res;

  // field bits are taken as they come, zero-filled when the store is wider
  assign in_pos   = in_tdata[POS_LSB +: INDEX_W];
  assign in_value = in_tdata[VAL_LSB +: VALUE_W];
  assign in_key   = in_tdata[KEY_LSB +: VALUE_W];

  assign in_tready = eng_idle;
  assign in_fire   = in_tvalid && in_tready;
  assign wr_en     = in_fire && (func_t'(in_tuser) == FUNC_WRITE)
                     && (32'(in_pos) < 32'(STORE_DEPTH));
  assign start     = in_fire && (func_t'(in_tuser) == FUNC_SEARCH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= COUNT_W'(1);
    end else if (cfg_wr_en) begin
      count_r <= cfg_wr_data;
    end
  end

  rsas_mem #(
    .DEPTH (STORE_DEPTH),
    .AW    (AW),
    .DW    (DATA_WIDTH)
  ) u_mem (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_addr  (AW'(in_pos)),
    .wr_data  (DATA_WIDTH'(in_value)),
    .rd0_addr (rd0_addr),
    .rd1_addr (rd1_addr),
    .rd0_data (rd0_data),
    .rd1_data (rd1_data)
  );

  rsas_search #(
    .DEPTH (STORE_DEPTH),
    .AW    (AW),
    .DW    (DATA_WIDTH),
    .BW    (BW)
  ) u_search (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .start_key (DATA_WIDTH'(in_key)),
    .count     (count_r),
    .idle      (eng_idle),
    .rd0_addr  (rd0_addr),
    .rd1_addr  (rd1_addr),
    .rd0_data  (rd0_data),
    .rd1_data  (rd1_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // output slot frees when empty or being drained this cycle
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_data_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_DATA_W - INDEX_W - 1)'(0), out_data_r.index, out_data_r.found};

endmodule
